[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that prop never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[hdl/rcfv_pkg.sv]
// ----------------------------------------------------------------------------
// rcfv_pkg
// Shared constants for the Rhie-Chow face velocity block.
// ----------------------------------------------------------------------------
package rcfv_pkg;

  localparam int unsigned DEF_MAX_CELLS = 32;
  localparam int unsigned VAL_W         = 32;
  // Cell word: vel_x, vel_y, vel_z, pressure, coefficient, fluid bit.
  localparam int unsigned WORD_W        = 5 * VAL_W + 1;

  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] KIND_FLUID = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MASK  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_EN = 3'd6;

endpackage

[hdl/rhie_chow_face_velocity.sv]
// ----------------------------------------------------------------------------
// rhie_chow_face_velocity
// Rhie-Chow face velocity over a stored 3-D grid of cells.
//
// A store transfer writes one cell and yields no result. A query transfer
// makes four reads of the face stencil through the one read port of the
// cell RAM, three gradient products on a shared multiplier, a 34-step
// bit-serial reciprocal of the mean coefficient, which dominates, and two
// partial products for the correction. One query is in flight at a time; a
// new transfer is taken while a finished result still waits in the output
// register. Faces out of range skip the reads and go straight to the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhie_chow_face_velocity #(
  parameter int unsigned MAX_CELLS_X = rcfv_pkg::DEF_MAX_CELLS,
  parameter int unsigned MAX_CELLS_Y = rcfv_pkg::DEF_MAX_CELLS,
  parameter int unsigned MAX_CELLS_Z = rcfv_pkg::DEF_MAX_CELLS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // axis, col, row, layer, vel_x, vel_y, vel_z, pressure, coefficient, cell_kind
  input  logic [rcfv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // operation
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // face_velocity
  output logic [rcfv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we_i,
  input  logic [rcfv_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);

  import rcfv_pkg::*;

  localparam int unsigned XW     = $clog2(MAX_CELLS_X);
  localparam int unsigned YW     = $clog2(MAX_CELLS_Y);
  localparam int unsigned ZW     = $clog2(MAX_CELLS_Z);
  localparam int unsigned ADDR_W = XW + YW + ZW;
  localparam logic [8:0] MAX_X = 9'(MAX_CELLS_X);
  localparam logic [8:0] MAX_Y = 9'(MAX_CELLS_Y);
  localparam logic [8:0] MAX_Z = 9'(MAX_CELLS_Z);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_GRAD  = 3'd3;
  localparam logic [2:0] S_RECIP = 3'd4;
  localparam logic [2:0] S_CORR  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [5:0]  DIV_TOP   = 6'd33;
  localparam logic [70:0] CORR_CLAMP = 71'(1) << 40;

  // Configuration
  logic [5:0]  size_x_q, size_y_q, size_z_q;
  logic [31:0] inv_x_q, inv_y_q, inv_z_q;
  logic        mask_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= 6'd32;
      size_y_q  <= 6'd32;
      size_z_q  <= 6'd32;
      inv_x_q   <= 32'd65536;
      inv_y_q   <= 32'd65536;
      inv_z_q   <= 32'd65536;
      mask_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SIZE_X:  size_x_q  <= cfg_data_i[5:0];
        CFG_SIZE_Y:  size_y_q  <= cfg_data_i[5:0];
        CFG_SIZE_Z:  size_z_q  <= cfg_data_i[5:0];
        CFG_INV_X:   inv_x_q   <= cfg_data_i;
        CFG_INV_Y:   inv_y_q   <= cfg_data_i;
        CFG_INV_Z:   inv_z_q   <= cfg_data_i;
        CFG_MASK_EN: mask_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input fields
  logic        in_op;
  logic [1:0]  in_axis, in_kind;
  logic [4:0]  in_col, in_row, in_layer;
  logic [31:0] in_vx, in_vy, in_vz, in_pr, in_co;

  assign in_op    = s_axis_tuser;
  assign in_axis  = s_axis_tdata[1:0];
  assign in_col   = s_axis_tdata[6:2];
  assign in_row   = s_axis_tdata[11:7];
  assign in_layer = s_axis_tdata[16:12];
  assign in_vx    = s_axis_tdata[48:17];
  assign in_vy    = s_axis_tdata[80:49];
  assign in_vz    = s_axis_tdata[112:81];
  assign in_pr    = s_axis_tdata[144:113];
  assign in_co    = s_axis_tdata[176:145];
  assign in_kind  = s_axis_tdata[178:177];

  logic [2:0] state_q, state_d;
  logic       s_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Range checks at accept
  logic [8:0] cx9, cy9, cz9, nx, ny, nz, c_ax, n_ax;
  logic       store_ok, face_bad;

  assign cx9 = {4'd0, in_col};
  assign cy9 = {4'd0, in_row};
  assign cz9 = {4'd0, in_layer};
  assign nx  = ({3'd0, size_x_q} > MAX_X) ? MAX_X : {3'd0, size_x_q};
  assign ny  = ({3'd0, size_y_q} > MAX_Y) ? MAX_Y : {3'd0, size_y_q};
  assign nz  = ({3'd0, size_z_q} > MAX_Z) ? MAX_Z : {3'd0, size_z_q};

  always_comb begin
    unique case (in_axis)
      AX_X:    begin c_ax = cx9; n_ax = nx; end
      AX_Y:    begin c_ax = cy9; n_ax = ny; end
      AX_Z:    begin c_ax = cz9; n_ax = nz; end
      default: begin c_ax = '0;  n_ax = '0; end
    endcase
  end

  assign store_ok = (cx9 < MAX_X) && (cy9 < MAX_Y) && (cz9 < MAX_Z);
  assign face_bad = (in_axis != AX_X && in_axis != AX_Y && in_axis != AX_Z) ||
                    cx9 >= nx || cy9 >= ny || cz9 >= nz || (c_ax + 9'd1) >= n_ax;

  // Cell RAM
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  assign ram_we    = s_acc && (in_op == OP_STORE) && store_ok;
  assign ram_waddr = {ZW'(cz9), YW'(cy9), XW'(cx9)};
  assign ram_wdata = {in_kind == KIND_FLUID, in_co, in_pr, in_vz, in_vy, in_vx};

  rcfv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (2 ** ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Query context
  logic [4:0]  cx_q, cy_q, cz_q;
  logic [1:0]  axis_q;
  logic [31:0] inv_q;
  logic        use_w_q, use_ee_q;
  logic [2:0]  rd_cnt_q;
  logic [1:0]  step_q;
  logic [5:0]  div_cnt_q;

  // Stencil: read P, E, W, EE in that order
  logic [8:0] off, ex, ey, ez;
  always_comb begin
    case (rd_cnt_q[1:0])
      2'd0:    off = 9'd0;
      2'd1:    off = 9'd1;
      2'd2:    off = 9'h1FF;
      default: off = 9'd2;
    endcase
  end
  assign ex = {4'd0, cx_q} + ((axis_q == AX_X) ? off : 9'd0);
  assign ey = {4'd0, cy_q} + ((axis_q == AX_Y) ? off : 9'd0);
  assign ez = {4'd0, cz_q} + ((axis_q == AX_Z) ? off : 9'd0);
  assign ram_raddr = {ZW'(ez), YW'(ey), XW'(ex)};
  assign ram_re    = (state_q == S_READ) && (rd_cnt_q < 3'd4);

  logic signed [31:0] rd_vel, rd_pr, rd_co;
  assign rd_vel = (axis_q == AX_X) ? ram_rdata[31:0] :
                  ((axis_q == AX_Y) ? ram_rdata[63:32] : ram_rdata[95:64]);
  assign rd_pr  = ram_rdata[127:96];
  assign rd_co  = ram_rdata[159:128];

  logic signed [31:0] v_p_q, v_e_q, p_p_q, p_e_q, p_w_q, p_ee_q, a_p_q, a_e_q;
  logic               f_p_q, f_e_q, f_w_q, f_ee_q;

  // Arithmetic
  logic signed [32:0] lin_q, sum_q;
  logic               pos_q;
  logic signed [49:0] sharp_q, gw_q, gee_q;
  logic [33:0]        rem_q, quo_q;
  logic [52:0]        mag_q;
  logic               neg_q;
  logic [87:0]        acc_q;
  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod_q;
  logic [31:0]        res_fv_q;
  logic [1:0]         res_st_q;

  logic               gp_en, ge_en;
  logic signed [49:0] gp_sel, ge_sel;
  logic signed [52:0] corr2;
  logic signed [32:0] d_pe_pp, d_pe_pw, d_pee_pp, vsum, asum;
  logic [33:0]        div_r2, div_den, dq_w;
  logic               div_ge;
  logic [70:0]        scaled;
  logic [40:0]        corr_mag;
  logic signed [43:0] lin_ext, corr_ext, res_w;
  logic [31:0]        sat_w;

  assign gp_en  = use_w_q  && (!mask_en_q || f_w_q);
  assign ge_en  = use_ee_q && (!mask_en_q || f_ee_q);
  assign gp_sel = gp_en ? gw_q  : sharp_q;
  assign ge_sel = ge_en ? gee_q : sharp_q;
  assign corr2  = $signed({{2{sharp_q[49]}}, sharp_q, 1'b0}) - 53'(gp_sel) - 53'(ge_sel);

  assign d_pe_pp  = 33'(p_e_q)  - 33'(p_p_q);
  assign d_pe_pw  = 33'(p_e_q)  - 33'(p_w_q);
  assign d_pee_pp = 33'(p_ee_q) - 33'(p_p_q);
  assign vsum     = 33'(v_p_q) + 33'(v_e_q);
  assign asum     = 33'(a_p_q) + 33'(a_e_q);

  // Restoring division of 2^33 by the coefficient sum, one bit a cycle
  assign div_r2  = {rem_q[32:0], div_cnt_q == DIV_TOP};
  assign div_den = {1'b0, sum_q[32:0]};
  assign div_ge  = div_r2 >= div_den;
  assign dq_w    = pos_q ? quo_q : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_GRAD) begin
      mul_b = $signed({3'd0, inv_q});
      case (step_q)
        2'd0:    mul_a = 35'(d_pe_pp);
        2'd1:    mul_a = 35'(d_pe_pw);
        default: mul_a = 35'(d_pee_pp);
      endcase
    end else if (state_q == S_CORR) begin
      mul_a = $signed({1'b0, dq_w});
      mul_b = (step_q == 2'd0) ? $signed({8'd0, mag_q[26:0]}) :
                                 $signed({9'd0, mag_q[52:27]});
    end
  end

  assign scaled   = acc_q[87:17];
  assign corr_mag = (scaled > CORR_CLAMP) ? CORR_CLAMP[40:0] : scaled[40:0];
  assign lin_ext  = 44'(lin_q);
  assign corr_ext = neg_q ? -$signed({3'd0, corr_mag}) : $signed({3'd0, corr_mag});
  assign res_w    = lin_ext - corr_ext;

  always_comb begin
    if (res_w[43:31] == {13{1'b0}} || res_w[43:31] == {13{1'b1}}) begin
      sat_w = res_w[31:0];
    end else if (res_w[43]) begin
      sat_w = 32'h8000_0000;
    end else begin
      sat_w = 32'h7FFF_FFFF;
    end
  end

  // Output register
  logic        out_valid_q;
  logic [31:0] out_fv_q;
  logic [1:0]  out_st_q;
  logic        out_load;

  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_fv_q;
  assign m_axis_tuser  = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_fv_q <= res_fv_q;
      out_st_q <= res_st_q;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && in_op == OP_QUERY) begin
          state_d = face_bad ? S_DONE : S_READ;
        end
      end
      S_READ:  if (rd_cnt_q == 3'd4) state_d = S_CHECK;
      S_CHECK: state_d = (mask_en_q && (!f_p_q || !f_e_q)) ? S_DONE : S_GRAD;
      S_GRAD:  if (step_q == 2'd3) state_d = S_RECIP;
      S_RECIP: if (div_cnt_q == 6'd0) state_d = S_CORR;
      S_CORR:  if (step_q == 2'd3) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      step_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_READ) begin
        rd_cnt_q <= rd_cnt_q + 3'd1;
      end else begin
        rd_cnt_q <= '0;
      end
      if (state_q == S_GRAD || state_q == S_CORR) begin
        step_q <= step_q + 2'd1;
      end else begin
        step_q <= '0;
      end
      if (state_q == S_RECIP) begin
        div_cnt_q <= div_cnt_q - 6'd1;
      end else begin
        div_cnt_q <= DIV_TOP;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        cx_q     <= in_col;
        cy_q     <= in_row;
        cz_q     <= in_layer;
        axis_q   <= in_axis;
        use_w_q  <= c_ax != 9'd0;
        use_ee_q <= (c_ax + 9'd2) < n_ax;
        inv_q    <= (in_axis == AX_X) ? inv_x_q : ((in_axis == AX_Y) ? inv_y_q : inv_z_q);
        res_fv_q <= '0;
        res_st_q <= ST_RANGE;
      end
      S_READ: begin
        case (rd_cnt_q)
          3'd1: begin
            v_p_q <= rd_vel; p_p_q <= rd_pr; a_p_q <= rd_co; f_p_q <= ram_rdata[160];
          end
          3'd2: begin
            v_e_q <= rd_vel; p_e_q <= rd_pr; a_e_q <= rd_co; f_e_q <= ram_rdata[160];
          end
          3'd3: begin
            p_w_q <= rd_pr; f_w_q <= ram_rdata[160];
          end
          3'd4: begin
            p_ee_q <= rd_pr; f_ee_q <= ram_rdata[160];
          end
          default: ;
        endcase
      end
      S_CHECK: begin
        lin_q    <= vsum >>> 1;
        sum_q    <= asum;
        pos_q    <= !asum[32] && (asum != 33'd0);
        rem_q    <= '0;
        quo_q    <= '0;
        res_fv_q <= '0;
        res_st_q <= ST_MASK;
      end
      S_GRAD: begin
        case (step_q)
          2'd1:    sharp_q <= prod_q[65:16];
          2'd2:    gw_q    <= prod_q[66:17];
          2'd3:    gee_q   <= prod_q[66:17];
          default: ;
        endcase
      end
      S_RECIP: begin
        rem_q <= div_ge ? div_r2 - div_den : div_r2;
        quo_q <= {quo_q[32:0], div_ge};
        if (div_cnt_q == 6'd0) begin
          mag_q <= corr2[52] ? 53'(-corr2) : 53'(corr2);
          neg_q <= corr2[52];
        end
      end
      S_CORR: begin
        case (step_q)
          2'd1:    acc_q <= 88'(prod_q[60:0]);
          2'd2:    acc_q <= acc_q + {prod_q[60:0], 27'd0};
          default: begin
            if (step_q == 2'd3) begin
              res_fv_q <= sat_w;
              res_st_q <= ST_OK;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  // Assertions
  `ASSERT_HOLDS(a_store_stays_idle, clk_i, rst_ni,
                s_acc && in_op == OP_STORE |=> state_q == S_IDLE,
                "store transfer left the sequencer busy")
  `ASSERT_HOLDS(a_done_waits, clk_i, rst_ni,
                state_q == S_DONE && m_axis_tvalid && !m_axis_tready |=> state_q == S_DONE,
                "result dropped while output register was full")
  `ASSERT_NEVER(a_flagged_zero, clk_i, rst_ni,
                m_axis_tvalid && m_axis_tuser != ST_OK && m_axis_tdata != '0,
                "flagged result carries a nonzero velocity")
  `ASSERT_HOLDS(a_div_count, clk_i, rst_ni,
                state_q == S_RECIP |-> div_cnt_q <= DIV_TOP,
                "reciprocal step count out of range")

endmodule

[hdl/rcfv_ram.sv]
// ----------------------------------------------------------------------------
// rcfv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcfv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
